// File: sv/spi_master_controller_defines.svh
// assertion helpers for the rtl, used by spm_core
`ifndef SPI_MASTER_CONTROLLER_DEFINES_SVH
`define SPI_MASTER_CONTROLLER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SPM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/spm_pkg.sv
package spm_pkg;

    localparam int DATA_BITS = 8;
    localparam int EDGE_BITS = 4;
    localparam int PRESCALE_BITS = 7;
    localparam logic [EDGE_BITS-1:0] LAST_EDGE = EDGE_BITS'(2 * DATA_BITS - 1);

    // item functions
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_WRITE  = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;
    localparam logic [1:0] FUNC_STATUS = 2'd3;

    // register indexes
    localparam logic [2:0] REG_ENABLE    = 3'd0;
    localparam logic [2:0] REG_LSB_FIRST = 3'd1;
    localparam logic [2:0] REG_CPOL      = 3'd2;
    localparam logic [2:0] REG_CPHA      = 3'd3;
    localparam logic [2:0] REG_RATE      = 3'd4;

    localparam int ADDR_BITS = 5;

    typedef struct packed {
        logic       enable;
        logic       lsb_first;
        logic       cpol;
        logic       cpha;
        logic [1:0] rate;
    } cfg_t;

    typedef struct packed {
        logic [1:0]           func;
        logic [DATA_BITS-1:0] write_data;
        logic [1:0]           clear_mask;
        logic                 miso;
    } item_t;

    typedef struct packed {
        logic                 sclk;
        logic                 mosi;
        logic [DATA_BITS-1:0] read_data;
        logic                 done_flag;
        logic                 collision_flag;
        logic                 busy;
    } result_t;

    // sclk half period in system clocks
    function automatic logic [PRESCALE_BITS:0] half_period(input logic [1:0] sel);
        logic [PRESCALE_BITS:0] hp;
        unique case (sel)
            2'd0: hp = 8'd2;
            2'd1: hp = 8'd8;
            2'd2: hp = 8'd32;
            default: hp = 8'd64;
        endcase
        return hp;
    endfunction

endpackage

// File: sv/spm_cfg.sv
module spm_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spm_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output spm_pkg::cfg_t                  cfg
);
    import spm_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] index;
    logic       wr;

    assign index = paddr[ADDR_BITS-1:2];
    assign wr    = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (index)
                REG_ENABLE:    cfg_next.enable    = pwdata[0];
                REG_LSB_FIRST: cfg_next.lsb_first = pwdata[0];
                REG_CPOL:      cfg_next.cpol      = pwdata[0];
                REG_CPHA:      cfg_next.cpha      = pwdata[0];
                REG_RATE:      cfg_next.rate      = pwdata[1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{enable: 1'b1, lsb_first: 1'b0, cpol: 1'b0, cpha: 1'b0, rate: 2'd0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (index)
            REG_ENABLE:    prdata[0]   = cfg_reg.enable;
            REG_LSB_FIRST: prdata[0]   = cfg_reg.lsb_first;
            REG_CPOL:      prdata[0]   = cfg_reg.cpol;
            REG_CPHA:      prdata[0]   = cfg_reg.cpha;
            REG_RATE:      prdata[1:0] = cfg_reg.rate;
            default:       prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/spm_core.sv
`include "spi_master_controller_defines.svh"

module spm_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  spm_pkg::item_t   item,
    input  spm_pkg::cfg_t    cfg,
    output spm_pkg::result_t result
);
    import spm_pkg::*;

    logic [DATA_BITS-1:0]     shift_reg_reg, shift_reg_next;
    logic [DATA_BITS-1:0]     rx_byte_reg, rx_byte_next;
    logic [EDGE_BITS-1:0]     bit_count_reg, bit_count_next;
    logic [PRESCALE_BITS-1:0] prescale_count_reg, prescale_count_next;
    logic                     clock_level_reg, clock_level_next;
    logic                     done_reg, done_next;
    logic                     collision_reg, collision_next;
    logic                     active_reg, active_next;
    logic                     sample_reg, sample_next;

    always_comb
    begin
        logic                   started;
        logic [PRESCALE_BITS:0] count_inc;
        logic                   leading;
        logic                   last;
        logic                   do_sample;
        logic                   do_shift;

        shift_reg_next      = shift_reg_reg;
        rx_byte_next        = rx_byte_reg;
        bit_count_next      = bit_count_reg;
        prescale_count_next = prescale_count_reg;
        clock_level_next    = clock_level_reg;
        done_next           = done_reg;
        collision_next      = collision_reg;
        active_next         = active_reg;
        sample_next         = sample_reg;
        started             = 1'b0;
        count_inc           = {1'b0, prescale_count_reg} + 1'b1;
        leading             = !bit_count_reg[0];
        last                = bit_count_reg == LAST_EDGE;
        do_sample           = cfg.cpha ? !leading : leading;
        do_shift            = last || (cfg.cpha ? (leading && bit_count_reg != '0) : !leading);

        // disable aborts a running exchange
        if (!cfg.enable && active_reg)
        begin
            active_next         = 1'b0;
            bit_count_next      = '0;
            prescale_count_next = '0;
            clock_level_next    = cfg.cpol;
        end

        // bus access
        unique case (item.func)
            FUNC_WRITE:
            begin
                if (active_next)
                begin
                    collision_next = 1'b1;
                end
                else if (cfg.enable)
                begin
                    shift_reg_next      = item.write_data;
                    active_next         = 1'b1;
                    bit_count_next      = '0;
                    prescale_count_next = '0;
                    clock_level_next    = cfg.cpol;
                    sample_next         = 1'b0;
                    started             = 1'b1;
                end
            end
            FUNC_STATUS:
            begin
                if (item.clear_mask[1])
                begin
                    done_next = 1'b0;
                end
                if (item.clear_mask[0])
                begin
                    collision_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        // prescaler and sclk edge; the starting beat does not count
        if (active_next && !started)
        begin
            if (count_inc >= half_period(cfg.rate))
            begin
                prescale_count_next = '0;
                if (do_sample)
                begin
                    sample_next = item.miso;
                end
                if (do_shift)
                begin
                    if (cfg.lsb_first)
                    begin
                        shift_reg_next = {sample_next, shift_reg_reg[DATA_BITS-1:1]};
                    end
                    else
                    begin
                        shift_reg_next = {shift_reg_reg[DATA_BITS-2:0], sample_next};
                    end
                end
                clock_level_next = !clock_level_reg;
                if (last)
                begin
                    rx_byte_next   = shift_reg_next;
                    done_next      = 1'b1;
                    active_next    = 1'b0;
                    bit_count_next = '0;
                end
                else
                begin
                    bit_count_next = bit_count_reg + 1'b1;
                end
            end
            else
            begin
                prescale_count_next = count_inc[PRESCALE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg_reg      <= '0;
            rx_byte_reg        <= '0;
            bit_count_reg      <= '0;
            prescale_count_reg <= '0;
            clock_level_reg    <= 1'b0;
            done_reg           <= 1'b0;
            collision_reg      <= 1'b0;
            active_reg         <= 1'b0;
            sample_reg         <= 1'b0;
        end
        else if (step)
        begin
            shift_reg_reg      <= shift_reg_next;
            rx_byte_reg        <= rx_byte_next;
            bit_count_reg      <= bit_count_next;
            prescale_count_reg <= prescale_count_next;
            clock_level_reg    <= clock_level_next;
            done_reg           <= done_next;
            collision_reg      <= collision_next;
            active_reg         <= active_next;
            sample_reg         <= sample_next;
        end
    end

    // result is the state after this beat
    always_comb
    begin
        result.sclk           = active_next ? clock_level_next : cfg.cpol;
        result.mosi           = cfg.lsb_first ? shift_reg_next[0] : shift_reg_next[DATA_BITS-1];
        result.read_data      = rx_byte_next;
        result.done_flag      = done_next;
        result.collision_flag = collision_next;
        result.busy           = active_next;
    end

    `SPM_ASSERT_NOW(a_idle_counters_clear, !active_reg,
        bit_count_reg == '0 && prescale_count_reg == '0, "idle with nonzero counters")
    `SPM_ASSERT_NOW(a_prescale_range, 1'b1,
        {1'b0, prescale_count_reg} < half_period(2'd3), "prescaler past longest half period")
    `SPM_ASSERT_NEXT(a_shift_holds, !step,
        $stable(shift_reg_reg) && $stable(bit_count_reg), "state moved without a beat")

endmodule

// File: sv/spi_master_controller.sv
// channel  dir   payload                                                    handshake
// in       in    func, write_data, clear_mask, miso                         in_valid/in_ready
// out      out   sclk, mosi, read_data, done_flag, collision_flag, busy_res out_valid/out_ready
// apb      in    paddr, pwdata, prdata (enable..rate, index at paddr[4:2])  psel/penable/pwrite
//
// one beat per cycle sustained while out_ready stays high: each input beat is one system clock tick of the spi engine
// result valid once the accepted input beat has passed the input register, then the result register
// the whole tick (prescaler, sclk edge, shift) is one pass of logic in the core
// rst_n is asynchronous; after reset enable is 1 and all spi state is clear
// a stalled result holds the result register; the input register takes one more beat,
// then in_ready drops until out_ready returns

module spi_master_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    // input beat
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    func,
    input  logic [spm_pkg::DATA_BITS-1:0] write_data,
    input  logic [1:0]                    clear_mask,
    input  logic                          miso,
    // result beat
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          sclk,
    output logic                          mosi,
    output logic [spm_pkg::DATA_BITS-1:0] read_data,
    output logic                          done_flag,
    output logic                          collision_flag,
    output logic                          busy_res,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spm_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import spm_pkg::*;

    // input stage
    logic    in_valid_reg, in_valid_next;
    item_t   item_reg;
    // result stage
    logic    out_valid_reg, out_valid_next;
    result_t result_reg;

    cfg_t    cfg;
    result_t core_result;
    logic    advance;

    assign pready = 1'b1;

    spm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // the held beat moves into the core when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{func: func, write_data: write_data,
                          clear_mask: clear_mask, miso: miso};
        end
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    spm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    assign out_valid      = out_valid_reg;
    assign sclk           = result_reg.sclk;
    assign mosi           = result_reg.mosi;
    assign read_data      = result_reg.read_data;
    assign done_flag      = result_reg.done_flag;
    assign collision_flag = result_reg.collision_flag;
    assign busy_res       = result_reg.busy;

endmodule

// File: bench/tb_spi_master_controller.sv
module tb_spi_master_controller;

    import spm_pkg::*;

    // run limit in system clocks, far above the slowest legal run
    localparam int CYCLE_LIMIT  = 200000;
    // random part: phases of fixed length, each with its own register setting
    localparam int PHASES       = 12;
    localparam int PHASE_BEATS  = 86;
    // long receiver hold-off, long enough to back the block up to its input
    localparam int HOLD_CYCLES  = 300;
    // results trail their input beat through the input and result registers; wait a little more
    localparam int SETTLE_WAIT  = 4;
    localparam int PRINT_CAP    = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           func;
    logic [DATA_BITS-1:0] write_data;
    logic [1:0]           clear_mask;
    logic                 miso;

    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 sclk;
    logic                 mosi;
    logic [DATA_BITS-1:0] read_data;
    logic                 done_flag;
    logic                 collision_flag;
    logic                 busy_res;

    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    // directed beats may carry a hand-written snapshot, travelling with the beat
    logic                 pin_flag;
    result_t              pin_snap;

    spi_master_controller DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .write_data     (write_data),
        .clear_mask     (clear_mask),
        .miso           (miso),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sclk           (sclk),
        .mosi           (mosi),
        .read_data      (read_data),
        .done_flag      (done_flag),
        .collision_flag (collision_flag),
        .busy_res       (busy_res),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 20 unit period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // shadow of the spi engine: registers and serial state
    // ---------------------------------------------------------------
    cfg_t                 cfg_now;
    logic [DATA_BITS-1:0] shift_q;
    logic [DATA_BITS-1:0] rx_q;
    logic [3:0]           edge_idx;
    logic [6:0]           pre_cnt;
    logic                 clk_lvl;
    logic                 done_b;
    logic                 coll_b;
    logic                 busy_b;
    logic                 miso_hold;

    // snapshots of pins and flags still owed by the block, oldest first
    result_t pending_snapshots[$];

    int mismatches = 0;
    int result_count = 0;
    int cycle_count = 0;

    // idling controls, in percent: gaps per sent beat, stall bursts per receiver check
    int  gap_pct = 0;
    int  stall_pct = 0;
    int  stall_left = 0;
    bit  hold_req = 1'b0;

    // sclk half period in system clocks
    function automatic logic [7:0] sclk_half(input logic [1:0] sel);
        logic [7:0] h;
        case (sel)
            2'd0:    h = 8'd2;
            2'd1:    h = 8'd8;
            2'd2:    h = 8'd32;
            default: h = 8'd64;
        endcase
        return h;
    endfunction

    // one sclk edge: sample on one phase, shift on the other, last edge always shifts
    function automatic void sclk_transition(input logic m);
        logic lead;
        logic is_last;
        logic do_sample;
        logic do_shift;
        lead      = ~edge_idx[0];
        is_last   = (edge_idx == 4'(2 * DATA_BITS - 1));
        do_sample = cfg_now.cpha ? ~lead : lead;
        do_shift  = is_last || (cfg_now.cpha ? (lead && edge_idx != 4'd0) : ~lead);
        if (do_sample)
            miso_hold = m;
        if (do_shift)
        begin
            if (cfg_now.lsb_first)
                shift_q = {miso_hold, shift_q[DATA_BITS-1:1]};
            else
                shift_q = {shift_q[DATA_BITS-2:0], miso_hold};
        end
        clk_lvl = ~clk_lvl;
        if (is_last)
        begin
            rx_q     = shift_q;
            done_b   = 1'b1;
            busy_b   = 1'b0;
            edge_idx = 4'd0;
        end
        else
            edge_idx = edge_idx + 4'd1;
    endfunction

    // one system clock of the engine: bus access first, then prescaler and sclk
    function automatic result_t spi_clock_tick(input item_t it);
        result_t    r;
        logic [7:0] nxt;
        logic       started;
        started = 1'b0;
        // enable dropped mid transfer: abort, nothing latched
        if (!cfg_now.enable && busy_b)
        begin
            busy_b   = 1'b0;
            edge_idx = 4'd0;
            pre_cnt  = 7'd0;
            clk_lvl  = cfg_now.cpol;
        end
        if (it.func == FUNC_WRITE)
        begin
            if (busy_b)
                coll_b = 1'b1;
            else if (cfg_now.enable)
            begin
                shift_q   = it.write_data;
                busy_b    = 1'b1;
                edge_idx  = 4'd0;
                pre_cnt   = 7'd0;
                clk_lvl   = cfg_now.cpol;
                miso_hold = 1'b0;
                started   = 1'b1;
            end
        end
        else if (it.func == FUNC_STATUS)
        begin
            if (it.clear_mask[1])
                done_b = 1'b0;
            if (it.clear_mask[0])
                coll_b = 1'b0;
        end
        // the starting beat does not count
        if (busy_b && !started)
        begin
            nxt = {1'b0, pre_cnt} + 8'd1;
            if (nxt >= sclk_half(cfg_now.rate))
            begin
                pre_cnt = 7'd0;
                sclk_transition(it.miso);
            end
            else
                pre_cnt = nxt[6:0];
        end
        r.sclk           = busy_b ? clk_lvl : cfg_now.cpol;
        r.mosi           = cfg_now.lsb_first ? shift_q[0] : shift_q[DATA_BITS-1];
        r.read_data      = rx_q;
        r.done_flag      = done_b;
        r.collision_flag = coll_b;
        r.busy           = busy_b;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP)
            $display("mismatch on %s at result %0d: got %0h, want %0h",
                     what, result_count, got, want);
        mismatches++;
    endtask

    // ---------------------------------------------------------------
    // monitor: input beats feed the shadow, result beats are compared
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : watch
        item_t   cur;
        result_t calc;
        result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                cur.func       = func;
                cur.write_data = write_data;
                cur.clear_mask = clear_mask;
                cur.miso       = miso;
                calc = spi_clock_tick(cur);
                pending_snapshots.push_back(pin_flag ? pin_snap : calc);
            end
            if (out_valid && out_ready)
            begin
                if (pending_snapshots.size() == 0)
                    flag_mismatch("unrequested result", 1, 0);
                else
                begin
                    want = pending_snapshots.pop_front();
                    if (sclk !== want.sclk)
                        flag_mismatch("sclk", sclk, want.sclk);
                    if (mosi !== want.mosi)
                        flag_mismatch("mosi", mosi, want.mosi);
                    if (read_data !== want.read_data)
                        flag_mismatch("read_data", read_data, want.read_data);
                    if (done_flag !== want.done_flag)
                        flag_mismatch("done_flag", done_flag, want.done_flag);
                    if (collision_flag !== want.collision_flag)
                        flag_mismatch("collision_flag", collision_flag, want.collision_flag);
                    if (busy_res !== want.busy)
                        flag_mismatch("busy_res", busy_res, want.busy);
                end
                result_count++;
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver: random stall bursts, plus one long hold-off on request
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (hold_req)
            begin
                stall_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else if (stall_left == 0 && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 11);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------

    // offer one beat and hold it until taken; may idle afterwards
    task automatic push_beat(input item_t it, input bit pin, input result_t want);
        in_valid   <= 1'b1;
        func       <= it.func;
        write_data <= it.write_data;
        clear_mask <= it.clear_mask;
        miso       <= it.miso;
        pin_flag   <= pin;
        pin_snap   <= want;
        do @(posedge clk); while (!in_ready);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // stop offering and wait until every owed result is back;
    // let the monitor see the next edge first so a beat taken at the last edge is already queued
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_snapshots.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // apb write, setup then access; only with the pipe empty
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENABLE:    cfg_now.enable    = val[0];
            REG_LSB_FIRST: cfg_now.lsb_first = val[0];
            REG_CPOL:      cfg_now.cpol      = val[0];
            REG_CPHA:      cfg_now.cpha      = val[0];
            REG_RATE:      cfg_now.rate      = val[1:0];
            default: ;
        endcase
    endtask

    // mostly well-formed traffic: start an exchange when idle, otherwise tick it along
    function automatic item_t pick_item();
        item_t it;
        int    roll;
        roll = $urandom_range(0, 99);
        if (roll < ((busy_b || !cfg_now.enable) ? 4 : 30))
            it.func = FUNC_WRITE;
        else if (roll < 45)
            it.func = FUNC_STATUS;
        else if (roll < 55)
            it.func = FUNC_READ;
        else
            it.func = FUNC_TICK;
        it.write_data = DATA_BITS'($urandom);
        it.clear_mask = 2'($urandom_range(0, 3));
        it.miso       = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // directed table row: either a register write or a beat
    typedef struct {
        bit          is_reg;
        logic [2:0]  reg_idx;
        logic [31:0] reg_val;
        item_t       it;
        bit          pinned;
        result_t     want;
    } row_t;

    function automatic result_t snap(input logic s, input logic m, input logic [7:0] rd,
                                     input logic d, input logic c, input logic b);
        result_t r;
        r.sclk           = s;
        r.mosi           = m;
        r.read_data      = rd;
        r.done_flag      = d;
        r.collision_flag = c;
        r.busy           = b;
        return r;
    endfunction

    function automatic row_t beat(input logic [1:0] f, input logic [7:0] wd,
                                  input logic [1:0] cm, input logic m);
        row_t r;
        r.is_reg        = 1'b0;
        r.reg_idx       = '0;
        r.reg_val       = '0;
        r.it.func       = f;
        r.it.write_data = wd;
        r.it.clear_mask = cm;
        r.it.miso       = m;
        r.pinned        = 1'b0;
        r.want          = '0;
        return r;
    endfunction

    function automatic row_t pinned_beat(input logic [1:0] f, input logic [7:0] wd,
                                         input logic [1:0] cm, input logic m,
                                         input result_t w);
        row_t r;
        r        = beat(f, wd, cm, m);
        r.pinned = 1'b1;
        r.want   = w;
        return r;
    endfunction

    function automatic row_t reg_row(input logic [2:0] idx, input logic [31:0] val);
        row_t r;
        r         = beat(FUNC_TICK, 8'h00, 2'd0, 1'b0);
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    initial
    begin : main
        row_t       plan[$];
        row_t       rw;
        item_t      it;
        result_t    zero_snap;
        logic [1:0] rate;
        int         p;
        int         n;

        // every input known from time zero
        in_valid   = 1'b0;
        func       = FUNC_TICK;
        write_data = '0;
        clear_mask = '0;
        miso       = 1'b0;
        pin_flag   = 1'b0;
        pin_snap   = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;

        // shadow reset state: enable on, everything else clear
        cfg_now        = '0;
        cfg_now.enable = 1'b1;
        shift_q   = '0;
        rx_q      = '0;
        edge_idx  = '0;
        pre_cnt   = '0;
        clk_lvl   = 1'b0;
        done_b    = 1'b0;
        coll_b    = 1'b0;
        busy_b    = 1'b0;
        miso_hold = 1'b0;
        zero_snap = '0;

        // directed table, reset setting: mode 0, msb first, /4
        // idle after reset: nothing moves whatever the access
        plan.push_back(pinned_beat(FUNC_TICK,   8'h00, 2'd0, 1'b1, zero_snap));
        plan.push_back(pinned_beat(FUNC_READ,   8'h00, 2'd0, 1'b0, zero_snap));
        plan.push_back(pinned_beat(FUNC_STATUS, 8'h00, 2'd3, 1'b0, zero_snap));
        // start with all ones: mosi shows the msb, sclk still at idle level
        plan.push_back(pinned_beat(FUNC_WRITE,  8'hFF, 2'd0, 1'b0,
                                   snap(1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1)));
        // write while busy: collision, byte ignored
        plan.push_back(pinned_beat(FUNC_WRITE,  8'h00, 2'd0, 1'b0,
                                   snap(1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1)));
        plan.push_back(beat(FUNC_TICK, 8'h00, 2'd0, 1'b1));
        plan.push_back(beat(FUNC_TICK, 8'h00, 2'd0, 1'b0));
        // polarity flipped mid transfer
        plan.push_back(reg_row(REG_CPOL, 32'd1));
        plan.push_back(beat(FUNC_TICK, 8'h00, 2'd0, 1'b1));
        plan.push_back(beat(FUNC_TICK, 8'h00, 2'd0, 1'b0));
        // bit order flipped mid transfer
        plan.push_back(reg_row(REG_LSB_FIRST, 32'd1));
        plan.push_back(beat(FUNC_TICK, 8'h00, 2'd0, 1'b1));
        plan.push_back(beat(FUNC_TICK, 8'h00, 2'd0, 1'b0));
        // slow down, let the prescaler climb, then speed up past its count
        plan.push_back(reg_row(REG_RATE, 32'd3));
        repeat (4) plan.push_back(beat(FUNC_TICK, 8'h00, 2'd0, 1'b1));
        plan.push_back(reg_row(REG_RATE, 32'd0));
        plan.push_back(beat(FUNC_TICK,   8'h00, 2'd0, 1'b1));
        plan.push_back(beat(FUNC_STATUS, 8'h00, 2'd1, 1'b0));
        // disable mid transfer: abort, then a write that must be dropped
        plan.push_back(reg_row(REG_ENABLE, 32'd0));
        plan.push_back(beat(FUNC_TICK,   8'h00, 2'd0, 1'b0));
        plan.push_back(beat(FUNC_WRITE,  8'h5A, 2'd0, 1'b1));
        plan.push_back(beat(FUNC_STATUS, 8'h00, 2'd2, 1'b0));
        // back on, mode 1, start a fresh exchange that runs into the random part
        plan.push_back(reg_row(REG_ENABLE, 32'd1));
        plan.push_back(reg_row(REG_CPOL, 32'd0));
        plan.push_back(reg_row(REG_LSB_FIRST, 32'd0));
        plan.push_back(reg_row(REG_CPHA, 32'd1));
        plan.push_back(beat(FUNC_WRITE, 8'h81, 2'd0, 1'b0));
        repeat (3) plan.push_back(beat(FUNC_TICK, 8'h00, 2'd0, 1'b1));

        // reset held, then released on a rising edge
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        stall_pct = 20;
        gap_pct   = 20;
        foreach (plan[k])
        begin
            rw = plan[k];
            if (rw.is_reg)
                apb_write(rw.reg_idx, rw.reg_val);
            else
                push_beat(rw.it, rw.pinned, rw.want);
        end

        // random phases; each starts with an empty pipe and a new setting,
        // transfers in flight carry over so mid-transfer changes get hit too
        for (p = 0; p < PHASES; p++)
        begin
            if (p < 4)
                rate = 2'(p);
            else if ($urandom_range(0, 3) == 0)
                rate = 2'($urandom_range(2, 3));
            else
                rate = 2'($urandom_range(0, 1));
            apb_write(REG_RATE, {30'd0, rate});
            // one phase with the engine off, and one with every bit set
            apb_write(REG_ENABLE, (p == 6) ? 32'd0 : 32'd1);
            apb_write(REG_LSB_FIRST, (p == 3) ? 32'd1 : 32'($urandom_range(0, 1)));
            apb_write(REG_CPOL, (p == 3) ? 32'd1 : 32'($urandom_range(0, 1)));
            apb_write(REG_CPHA, (p == 3) ? 32'd1 : 32'($urandom_range(0, 1)));

            // the last phase runs without idling on either side
            if (p == PHASES - 1)
            begin
                stall_pct = 0;
                gap_pct   = 0;
            end
            else
            begin
                n = $urandom_range(0, 2);
                stall_pct = (n == 0) ? 0 : ((n == 1) ? 20 : 50);
                n = $urandom_range(0, 2);
                gap_pct = (n == 0) ? 0 : ((n == 1) ? 20 : 50);
            end

            // receiver goes quiet for a long stretch while beats keep coming
            if (p == 2)
                hold_req = 1'b1;

            for (n = 0; n < PHASE_BEATS; n++)
            begin
                it = pick_item();
                push_beat(it, 1'b0, zero_snap);
            end
        end

        settle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
